@@ sv/pai_pkg.sv @@
package pai_pkg;

    localparam int POS_W   = 12;
    localparam int ANGLE_W = 17;
    localparam int SLOT_W  = 4;
    localparam int ENT_W   = 5;
    localparam int CFG_IDX_W = 2;
    localparam int TBL_ADDR_MAX_W = 8;

    // product of an 18-bit signed angle term and a 13-bit signed span term
    localparam int PROD_W = 31;
    // 2 * total + span, total below 2^29
    localparam int NUM_W  = 30;

    localparam logic [POS_W-1:0] POS_FULL = 12'hfff;

    localparam logic CMD_CONVERT = 1'b0;
    localparam logic CMD_LOAD    = 1'b1;

    localparam logic [1:0] PATH_LINEAR   = 2'd0;
    localparam logic [1:0] PATH_TABLE    = 2'd1;
    localparam logic [1:0] PATH_FALLBACK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_USE_TABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES   = 2'd3;

    localparam logic [ANGLE_W-1:0] MAX_ANGLE_RESET = 17'd92160;

    typedef struct packed {
        logic                cmd;
        logic [SLOT_W-1:0]   entry_index;
        logic [POS_W-1:0]    entry_position;
        logic [ANGLE_W-1:0]  entry_angle;
        logic [POS_W-1:0]    position;
    } t_in;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic [1:0]         path;
    } t_out;

    typedef struct packed {
        logic                      en;
        logic [TBL_ADDR_MAX_W-1:0] addr;
        logic [POS_W-1:0]          position;
        logic [ANGLE_W-1:0]        angle;
    } t_tbl_wr;

endpackage

@@ sv/pai_bp_table.sv @@
module pai_bp_table
    import pai_pkg::*;
#(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic               i_clk,
    input  t_tbl_wr            i_wr,
    input  logic [ADDR_W-1:0]  i_rd_addr,
    output logic [POS_W-1:0]   o_rd_position,
    output logic [ANGLE_W-1:0] o_rd_angle
);

    logic [POS_W-1:0]   r_pos_mem [DEPTH];
    logic [ANGLE_W-1:0] r_ang_mem [DEPTH];
    logic [POS_W-1:0]   r_rd_pos;
    logic [ANGLE_W-1:0] r_rd_ang;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_pos_mem[i_wr.addr[ADDR_W-1:0]] <= i_wr.position;
            r_ang_mem[i_wr.addr[ADDR_W-1:0]] <= i_wr.angle;
        end
        r_rd_pos <= r_pos_mem[i_rd_addr];
        r_rd_ang <= r_ang_mem[i_rd_addr];
    end

    assign o_rd_position = r_rd_pos;
    assign o_rd_angle    = r_rd_ang;

endmodule

@@ sv/pai_serial_div.sv @@
module pai_serial_div
    import pai_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [NUM_W-1:0]   i_num,
    input  logic [POS_W-1:0]   i_den,
    output logic               o_done,
    output logic [ANGLE_W-1:0] o_quot
);

    // divides by 2*den; the quotient is known to fit in ANGLE_W bits, so the
    // remainder starts from the bits above the quotient field
    logic [POS_W:0]       r_rem;
    logic [ANGLE_W-1:0]   r_q;
    logic [POS_W-1:0]     r_den;
    logic [ENT_W-1:0]     r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [POS_W:0]       n_rem;
    logic [POS_W+1:0]     trial;
    logic [POS_W+1:0]     dd;
    logic                 ge;

    always_comb begin
        dd    = {1'b0, r_den, 1'b0};
        trial = {r_rem, r_q[ANGLE_W-1]};
        ge    = (trial >= dd);
        n_rem = ge ? (POS_W+1)'(trial - dd) : trial[POS_W:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == ENT_W'(ANGLE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[NUM_W-1:ANGLE_W];
            r_q   <= i_num[ANGLE_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[ANGLE_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

@@ sv/position_to_angle_interpolator_core.sv @@
// Converts a 12-bit position to an angle in degrees times 256. A word with
// cmd set to load writes one breakpoint in the accept cycle and busy stays
// low, so the next word can follow at once; a load to a slot at or beyond
// TABLE_DEPTH is dropped. A convert word raises busy until its result has
// been computed: a start step, a scan of the breakpoints when the table is
// in use (the scan stops once both brackets are found, at most the clamped
// entry count) followed by a check of the span, two products on the shared
// multiplier, a step to load the divider, the bit-serial divider and a step
// to take its quotient. The result is shown on o_result for exactly one
// cycle with o_done high, in the first cycle with busy low again; the
// receiver cannot stall it and must take it then. Configuration writes are
// taken at any time (o_cfg_ready is always high) but should only be made
// while busy is low.
module position_to_angle_interpolator_core
    import pai_pkg::*;
#(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_in                  i_item,
    output logic                 o_done,
    output t_out                 o_result,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ANGLE_W-1:0]   i_cfg_data
);

    localparam int ADDR_W = (TABLE_DEPTH > 2) ? $clog2(TABLE_DEPTH) : 1;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SCAN  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_MUL0  = 3'd3;
    localparam logic [2:0] ST_MUL1  = 3'd4;
    localparam logic [2:0] ST_DIVGO = 3'd5;
    localparam logic [2:0] ST_DIV   = 3'd6;

    // configuration
    logic               r_use_table;
    logic [ANGLE_W-1:0] r_min_angle;
    logic [ANGLE_W-1:0] r_max_angle;
    logic [ENT_W-1:0]   r_entries;

    // sequencer and working registers
    logic [2:0]          r_state;
    logic [POS_W-1:0]    r_p;
    logic [POS_W-1:0]    r_p0;
    logic [POS_W-1:0]    r_p1;
    logic [ANGLE_W-1:0]  r_a0;
    logic [ANGLE_W-1:0]  r_a1;
    logic                r_have_lo;
    logic                r_have_hi;
    logic [ENT_W-1:0]    r_cnt;
    logic [ENT_W-1:0]    r_n;
    logic [1:0]          r_path;
    logic signed [PROD_W-1:0] r_acc;
    logic                r_out_vld;
    t_out                r_out;

    logic [ENT_W-1:0]    n_clamped;
    logic                accept;
    logic                slot_ok;
    logic [ADDR_W+SLOT_W-1:0] slot_ext;
    logic [ADDR_W+ENT_W-1:0]  next_idx;
    logic [ADDR_W-1:0]   rd_addr;
    t_tbl_wr             tbl_wr;
    logic [POS_W-1:0]    rd_pos;
    logic [ANGLE_W-1:0]  rd_ang;

    logic [POS_W-1:0]    n_p0;
    logic [POS_W-1:0]    n_p1;
    logic [ANGLE_W-1:0]  n_a0;
    logic [ANGLE_W-1:0]  n_a1;
    logic                n_have_lo;
    logic                n_have_hi;
    logic                scan_last;

    logic [POS_W-1:0]    span;
    logic signed [ANGLE_W:0] mul_a;
    logic signed [POS_W:0]   mul_b;
    logic signed [PROD_W-1:0] prod;
    logic [NUM_W-1:0]    div_num;
    logic                div_done;
    logic [ANGLE_W-1:0]  div_quot;

    assign accept   = start && !busy;
    assign busy     = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    assign n_clamped = (32'(r_entries) > TABLE_DEPTH) ? ENT_W'(TABLE_DEPTH) : r_entries;

    // table write port
    assign slot_ok  = (32'(i_item.entry_index) < TABLE_DEPTH);
    assign slot_ext = (ADDR_W+SLOT_W)'(i_item.entry_index);

    always_comb begin
        tbl_wr.en       = accept && (i_item.cmd == CMD_LOAD) && slot_ok;
        tbl_wr.addr     = TBL_ADDR_MAX_W'(slot_ext[ADDR_W-1:0]);
        tbl_wr.position = i_item.entry_position;
        tbl_wr.angle    = i_item.entry_angle;
    end

    // entry 0 is read while idle, so its data is there in the first scan cycle
    assign next_idx = (ADDR_W+ENT_W)'(r_cnt) + 1'b1;
    assign rd_addr  = (r_state == ST_SCAN) ? next_idx[ADDR_W-1:0] : '0;

    pai_bp_table #(
        .DEPTH  (TABLE_DEPTH),
        .ADDR_W (ADDR_W)
    ) u_table (
        .i_clk         (i_clk),
        .i_wr          (tbl_wr),
        .i_rd_addr     (rd_addr),
        .o_rd_position (rd_pos),
        .o_rd_angle    (rd_ang)
    );

    // bracket update for the entry whose data is on the read port
    always_comb begin
        n_p0      = r_p0;
        n_p1      = r_p1;
        n_a0      = r_a0;
        n_a1      = r_a1;
        n_have_lo = r_have_lo;
        n_have_hi = r_have_hi;
        if (rd_pos <= r_p) begin
            n_p0      = rd_pos;
            n_a0      = rd_ang;
            n_have_lo = 1'b1;
        end else begin
            n_p1      = rd_pos;
            n_a1      = rd_ang;
            n_have_hi = 1'b1;
        end
        scan_last = (n_have_lo && n_have_hi) || (next_idx == (ADDR_W+ENT_W)'(r_n));
    end

    // shared multiplier: a0 * span first, then (a1 - a0) * (p - p0)
    assign span = r_p1 - r_p0;

    always_comb begin
        if (r_state == ST_MUL1) begin
            mul_a = $signed({1'b0, r_a1}) - $signed({1'b0, r_a0});
            mul_b = $signed({1'b0, POS_W'(r_p - r_p0)});
        end else begin
            mul_a = $signed({1'b0, r_a0});
            mul_b = $signed({1'b0, span});
        end
        prod = PROD_W'(mul_a * mul_b);
    end

    // round to nearest: (2 * total + span) / (2 * span)
    assign div_num = NUM_W'({r_acc[NUM_W-2:0], 1'b0}) + NUM_W'(span);

    pai_serial_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == ST_DIVGO),
        .i_num   (div_num),
        .i_den   (span),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_table <= 1'b0;
            r_min_angle <= '0;
            r_max_angle <= MAX_ANGLE_RESET;
            r_entries   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_USE_TABLE: r_use_table <= i_cfg_data[0];
                CFG_MIN_ANGLE: r_min_angle <= i_cfg_data;
                CFG_MAX_ANGLE: r_max_angle <= i_cfg_data;
                CFG_ENTRIES:   r_entries   <= i_cfg_data[ENT_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    if (accept && (i_item.cmd == CMD_CONVERT)) begin
                        if (r_use_table && (n_clamped != '0)) begin
                            r_state <= ST_SCAN;
                        end else begin
                            r_state <= ST_MUL0;
                        end
                    end
                end
                ST_SCAN: begin
                    if (scan_last) begin
                        r_state <= ST_CHECK;
                    end
                end
                ST_CHECK: r_state <= ST_MUL0;
                ST_MUL0:  r_state <= ST_MUL1;
                ST_MUL1:  r_state <= ST_DIVGO;
                ST_DIVGO: r_state <= ST_DIV;
                ST_DIV: begin
                    if (div_done) begin
                        r_state   <= ST_IDLE;
                        r_out_vld <= 1'b1;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_p       <= i_item.position;
                r_p0      <= '0;
                r_p1      <= POS_FULL;
                r_a0      <= r_min_angle;
                r_a1      <= r_max_angle;
                r_have_lo <= 1'b0;
                r_have_hi <= 1'b0;
                r_cnt     <= '0;
                r_n       <= n_clamped;
                r_path    <= (r_use_table && (n_clamped != '0)) ? PATH_TABLE : PATH_LINEAR;
            end
            ST_SCAN: begin
                r_p0      <= n_p0;
                r_p1      <= n_p1;
                r_a0      <= n_a0;
                r_a1      <= n_a1;
                r_have_lo <= n_have_lo;
                r_have_hi <= n_have_hi;
                r_cnt     <= r_cnt + 1'b1;
            end
            ST_CHECK: begin
                // empty or reversed span: plain scaling over the full range
                if (r_p1 <= r_p0) begin
                    r_p0   <= '0;
                    r_p1   <= POS_FULL;
                    r_a0   <= r_min_angle;
                    r_a1   <= r_max_angle;
                    r_path <= PATH_FALLBACK;
                end
            end
            ST_MUL0: r_acc <= prod;
            ST_MUL1: r_acc <= r_acc + prod;
            ST_DIVGO, ST_DIV: ;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DIV) && div_done) begin
            r_out.angle <= div_quot;
            r_out.path  <= r_path;
        end
    end

    assign o_done   = r_out_vld;
    assign o_result = r_out;

    // a result strobe is never raised back to back
    a_done_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobe held for two cycles");

    // the divider only finishes while the sequencer waits for it
    a_div_when_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide state");

    // the span is positive once the multiply starts
    a_span_positive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL0) |-> (r_p1 > r_p0))
        else $error("zero or negative span reached the multiplier");

    // a load word leaves the block free in the next cycle
    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_item.cmd == CMD_LOAD)) |=> !busy)
        else $error("load word made the block busy");

    // the scan never visits more entries than are in use
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN) |-> (r_cnt < r_n))
        else $error("table scan ran past the entry count");

endmodule
